/* hdl/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, defaults and register codes for the page translation block.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Fixed field widths of the translation transaction
  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int OFFSET_W   = 8;
  localparam int FRAME_W    = 8;
  localparam int PAGE_COUNT = 256;

  // Default sizing of the block
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int FRAME_TOTAL_DEF = 256;
  localparam int AGE_BITS_DEF    = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from paddr bit 2
  typedef enum logic {
    REG_POLICY = 1'b0,
    REG_NONE   = 1'b1
  } reg_index_t;

  // Victim choice on a TLB fill
  typedef enum logic {
    POL_FIFO = 1'b0,
    POL_LRU  = 1'b1
  } policy_t;

endpackage

/* hdl/tlbpt_ram.sv */
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/tlbpt_lru_pick.sv */
// ----------------------------------------------------------------------------
// tlbpt_lru_pick
// Comparator tree that finds the oldest TLB entry; ties go to the highest
// index.
// ----------------------------------------------------------------------------
module tlbpt_lru_pick
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int AGE_BITS    = AGE_BITS_DEF
) (
  input  logic [AGE_BITS-1:0]            ages [TLB_ENTRIES],
  output logic [$clog2(TLB_ENTRIES)-1:0] victim
);

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam int LEAVES = 1 << IDX_W;

  // Heap-ordered tree nodes: node 1 is the root, leaves start at LEAVES
  logic [AGE_BITS-1:0] nd_age [1:2*LEAVES-1];
  logic [IDX_W-1:0]    nd_idx [1:2*LEAVES-1];
  logic                nd_ok  [1:2*LEAVES-1];

  // Load leaves; padding leaves never win
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < TLB_ENTRIES) begin : g_real
      assign nd_age[LEAVES+i] = ages[i];
      assign nd_idx[LEAVES+i] = IDX_W'(i);
      assign nd_ok[LEAVES+i]  = 1'b1;
    end else begin : g_pad
      assign nd_age[LEAVES+i] = '0;
      assign nd_idx[LEAVES+i] = '0;
      assign nd_ok[LEAVES+i]  = 1'b0;
    end
  end

  // Reduce pairs; the right child holds the higher indices and wins ties
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic take_right;
    assign take_right = nd_ok[2*n+1] &&
                        (!nd_ok[2*n] || (nd_age[2*n+1] >= nd_age[2*n]));
    assign nd_age[n] = take_right ? nd_age[2*n+1] : nd_age[2*n];
    assign nd_idx[n] = take_right ? nd_idx[2*n+1] : nd_idx[2*n];
    assign nd_ok[n]  = nd_ok[2*n] || nd_ok[2*n+1];
  end

  assign victim = nd_idx[1];

endmodule

/* hdl/tlb_page_translation.sv */
// ----------------------------------------------------------------------------
// tlb_page_translation
// Logical-to-physical page translation through a TLB and a page table.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with logical_address; the transaction is taken at the edge
//   where start is high and busy is low. busy stays high for one cycle while
//   the page table read returns and the TLB is updated.
//   The result appears on frame_number, page_offset, tlb_hit and page_fault
//   for exactly one cycle with done high; done is registered from busy, and
//   the receiver takes the result while done is high; it cannot stall the
//   block.
//   A new transaction may be started in the cycle where done is high; the
//   block takes no new translation while busy is high, since the page-table
//   frame RAM read and the TLB fill, which the next lookup must see, both
//   complete in the busy cycle.
//   The TLB lookup and aging happen at the accept edge; the fill, page-table
//   write and frame allocation happen at the following edge.
//   Reset clears all TLB and page-table valid bits, the ages, the FIFO head,
//   the frame allocator and the policy register; no sweep is needed. The APB
//   port sets replacement_policy (bit 0 at address 0); the user must write it
//   only while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tlb_page_translation
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int FRAME_TOTAL = FRAME_TOTAL_DEF,
  parameter int AGE_BITS    = AGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // translation transaction
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     logical_address,
  output logic                  done,
  output logic [FRAME_W-1:0]    frame_number,
  output logic [OFFSET_W-1:0]   page_offset,
  output logic                  tlb_hit,
  output logic                  page_fault,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);
  localparam logic [FRAME_W-1:0]  FRAME_LAST = FRAME_W'(FRAME_TOTAL - 1);
  localparam logic [IDX_W-1:0]    SLOT_LAST = IDX_W'(TLB_ENTRIES - 1);

  // Control state
  logic                 acc;
  logic                 policy;
  logic [IDX_W-1:0]     fifo_head;
  logic [FRAME_W-1:0]   next_free;
  logic [TLB_ENTRIES-1:0] tlb_vld;
  logic [AGE_BITS-1:0]  tlb_age [TLB_ENTRIES];
  logic [PAGE_COUNT-1:0] pt_vld;

  // Payload state
  logic [PAGE_W-1:0]    tlb_pg  [TLB_ENTRIES];
  logic [FRAME_W-1:0]   tlb_frm [TLB_ENTRIES];
  logic [PAGE_W-1:0]    page_q;
  logic [OFFSET_W-1:0]  offset_q;
  logic                 hit_q;
  logic [FRAME_W-1:0]   hit_frame_q;
  logic                 pt_vld_q;

  // Lookup and completion signals
  logic [PAGE_W-1:0]    page_in;
  logic [TLB_ENTRIES-1:0] match;
  logic                 hit_any;
  logic [FRAME_W-1:0]   hit_frame;
  logic                 miss;
  logic                 fault;
  logic [FRAME_W-1:0]   ram_rdata;
  logic [FRAME_W-1:0]   frame_res;
  logic [IDX_W-1:0]     lru_slot;
  logic [IDX_W-1:0]     fill_slot;
  logic                 cfg_wr;

  assign acc     = start && !busy;
  assign page_in = logical_address[ADDR_W-1:OFFSET_W];

  // Compare the page against every TLB entry; the highest match supplies
  // the frame
  always_comb begin
    hit_any   = 1'b0;
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_vld[i] && (tlb_pg[i] == page_in);
      if (match[i]) begin
        hit_any   = 1'b1;
        hit_frame = tlb_frm[i];
      end
    end
  end

  // Page-table frame store
  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_pt_ram (
    .clk   (clk),
    .we    (busy && fault),
    .waddr (page_q),
    .wdata (next_free),
    .re    (acc),
    .raddr (page_in),
    .rdata (ram_rdata)
  );

  // Oldest entry, seen on the ages already bumped by this lookup
  tlbpt_lru_pick #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .AGE_BITS    (AGE_BITS)
  ) u_lru_pick (
    .ages   (tlb_age),
    .victim (lru_slot)
  );

  // Resolve the translation in the busy cycle
  assign miss      = !hit_q;
  assign fault     = miss && !pt_vld_q;
  assign frame_res = hit_q ? hit_frame_q : (pt_vld_q ? ram_rdata : next_free);
  assign fill_slot = (policy == POL_LRU) ? lru_slot : fifo_head;

  // Sequencing, policy, FIFO head and frame allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      policy    <= POL_FIFO;
      fifo_head <= '0;
      next_free <= '0;
    end else begin
      done <= busy;
      if (acc) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        if (miss && policy == POL_FIFO) begin
          fifo_head <= (fifo_head == SLOT_LAST) ? '0 : fifo_head + 1'b1;
        end
        if (fault) begin
          next_free <= (next_free == FRAME_LAST) ? '0 : next_free + 1'b1;
        end
      end
      if (cfg_wr) begin
        policy <= pwdata[0];
      end
    end
  end

  // TLB valid bits and ages: age on lookup, clear on fill
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_vld <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_age[i] <= '0;
      end
    end else if (acc) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (match[i]) begin
          tlb_age[i] <= AGE_ONE;
        end else if (tlb_age[i] != AGE_MAX) begin
          tlb_age[i] <= tlb_age[i] + 1'b1;
        end
      end
    end else if (busy && miss) begin
      tlb_vld[fill_slot] <= 1'b1;
      tlb_age[fill_slot] <= '0;
    end
  end

  // Page-table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_vld <= '0;
    end else if (busy && fault) begin
      pt_vld[page_q] <= 1'b1;
    end
  end

  // Capture the lookup and deliver the result
  always_ff @(posedge clk) begin
    if (acc) begin
      page_q      <= page_in;
      offset_q    <= logical_address[OFFSET_W-1:0];
      hit_q       <= hit_any;
      hit_frame_q <= hit_frame;
      pt_vld_q    <= pt_vld[page_in];
    end
    if (busy) begin
      frame_number <= frame_res;
      page_offset  <= offset_q;
      tlb_hit      <= hit_q;
      page_fault   <= fault;
      if (miss) begin
        tlb_pg[fill_slot]  <= page_q;
        tlb_frm[fill_slot] <= frame_res;
      end
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (reg_index_t'(paddr[2]) == REG_POLICY);

  always_comb begin
    prdata = '0;
    if (reg_index_t'(paddr[2]) == REG_POLICY) begin
      prdata[0] = policy;
    end
  end

  // Checks
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("busy phase did not complete in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> busy)
    else $error("accepted transaction did not enter the busy phase");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    done |-> !(tlb_hit && page_fault))
    else $error("TLB hit reported together with a page fault");

  a_miss_maps_page: assert property (@(posedge clk) disable iff (rst)
    (done && !tlb_hit) |-> (pt_vld[page_q] && tlb_vld != '0))
    else $error("TLB miss left the page unmapped");

  a_lru_oldest: assert property (@(posedge clk) disable iff (rst)
    (busy && miss && policy == POL_LRU) |-> (tlb_age[lru_slot] >= tlb_age[0]))
    else $error("LRU victim is younger than entry zero");

endmodule
